// ----- rtl/ghi_pkg.sv -----
// ghi_pkg: shared types, constants and command codes for the grid height interpolator
// no dependencies
`timescale 1ns / 1ps
package ghi_pkg;
	localparam int MaxPointsDef = 512;
	localparam int FracBitsDef  = 16;

	localparam logic [1:0] CMD_STORE = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [2:0] REG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_ORIGIN_X = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
	localparam logic [2:0] REG_INV_SPC  = 3'd3;
	localparam logic [2:0] REG_COLUMNS  = 3'd4;
	localparam logic [2:0] REG_ROWS     = 3'd5;

	localparam logic [31:0] INV_SPC_RESET = 32'd838861;

	// item as held in the queue between front and back
	typedef struct packed {
		logic [1:0]         cmd;
		logic [8:0]         col_index;
		logic [8:0]         row_index;
		logic signed [15:0] probed_height;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
	} item_t;
endpackage

// ----- rtl/ghi_front.sv -----
// ghi_front: input side, a two-entry item queue that decouples input from the back end
// depends on ghi_pkg
`timescale 1ns / 1ps
module ghi_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ghi_pkg::item_t in_item,
	output logic          q_valid,
	input  logic          q_take,
	output ghi_pkg::item_t q_item
);
	ghi_pkg::item_t mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = cnt_q[1];
	assign push     = in_valid && !in_stall;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (q_take) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end
endmodule

// ----- rtl/ghi_back.sv -----
// ghi_back: sequencer that stores points, clears marks and interpolates queries
// depends on ghi_pkg
`timescale 1ns / 1ps
module ghi_back #(
	parameter int MAX_POINTS = ghi_pkg::MaxPointsDef,
	parameter int FRAC_BITS  = ghi_pkg::FracBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_take,
	input  ghi_pkg::item_t     q_item,
	input  logic               map_enable,
	input  logic signed [23:0] origin_x,
	input  logic signed [23:0] origin_y,
	input  logic [31:0]        inverse_spacing,
	input  logic [9:0]         columns,
	input  logic [9:0]         rows,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] height_error,
	output logic               found
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int F  = FRAC_BITS;
	// mark epoch width; epoch 0 means never marked
	localparam int EW = 4;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001, S_MAP  = 9'b000000010, S_CLAMP = 9'b000000100,
		S_RD   = 9'b000001000, S_WGT  = 9'b000010000, S_MUL  = 9'b000100000,
		S_SUM  = 9'b001000000, S_OUT  = 9'b010000000, S_WIPE = 9'b100000000
	} state_t;
	state_t state_q;

	logic signed [15:0] hmem [MAX_POINTS];
	// per point epoch mark: a point is valid when its mark equals the current epoch
	logic [EW-1:0] emem [MAX_POINTS];
	logic [EW-1:0] epoch_q;
	logic [AW-1:0] wipe_q;

	ghi_pkg::item_t it_q;
	logic [9:0]  nc, nr;
	assign nc = (columns == 10'd0) ? 10'd1 : columns;
	assign nr = (rows == 10'd0) ? 10'd1 : rows;

	// store address, products fit 19 bits
	logic [18:0] st_idx;
	assign st_idx = 19'(q_item.row_index * nc) + 19'(q_item.col_index);

	// mapping: 25-bit diff times 32-bit spacing, taken from the held item
	logic signed [24:0] dx, dy;
	assign dx = 25'(it_q.pos_x) - 25'(origin_x);
	assign dy = 25'(it_q.pos_y) - 25'(origin_y);
	logic signed [57:0] px_q, py_q;

	// clamped cell and fraction
	logic xe_q, ye_q;
	logic [F-1:0] fx_q, fy_q;
	logic [3:0] rd_cnt_q;
	logic [19:0] base_q;
	logic [3:0] v_q;
	logic signed [15:0] h_q [4];

	function automatic logic [9:0] clampc(input logic signed [57:0] p,
		input logic [9:0] n, output logic e);
		logic signed [25:0] c;
		c = p[57:32];
		if (c < 0) begin e = 1'b1; clampc = 10'd0; end
		else if (c >= $signed({16'd0, n}) - 26'sd1) begin e = 1'b1; clampc = n - 10'd1; end
		else begin e = 1'b0; clampc = c[9:0]; end
	endfunction

	// corner addresses: 0 00, 1 10, 2 01, 3 11
	logic [19:0] caddr [4];
	logic        cin   [4];
	always_comb begin
		caddr[0] = base_q;
		caddr[1] = base_q + 20'd1;
		caddr[2] = base_q + 20'(nc);
		caddr[3] = base_q + 20'(nc) + 20'd1;
		cin[0] = 1'b1;
		cin[1] = !xe_q;
		cin[2] = !ye_q;
		cin[3] = !xe_q && !ye_q;
	end
	logic [1:0] ridx;
	assign ridx = rd_cnt_q[1:0];
	logic [19:0] raddr;
	assign raddr = caddr[ridx];
	logic rvalid_s1;
	logic [1:0] ridx_s1;
	logic signed [15:0] rdata_s1;
	logic [EW-1:0] mark_s1;
	logic vok_s1;
	logic rhit_s1;
	assign rhit_s1 = vok_s1 && (mark_s1 == epoch_q);

	// weights, all up to 2F, as F+2 bits
	localparam logic [F+1:0] ONE = (F+2)'(1) << F;
	localparam logic [F+1:0] TWO = (F+2)'(2) << F;
	logic [F+1:0] w_q [4];
	logic [1:0]   sh_q; // 0: none, 1: F, 2: F+1, 3: 2F
	logic [F+1:0] fxe, fye, gxe, gye;
	assign fxe = (F+2)'(fx_q);
	assign fye = (F+2)'(fy_q);
	assign gxe = ONE - fxe;
	assign gye = ONE - fye;

	logic signed [2*F+20:0] p_q [4];
	logic signed [2*F+22:0] acc;
	logic signed [2*F+22:0] rnd;

	always_comb begin
		acc = (2*F+23)'(p_q[0]) + (2*F+23)'(p_q[1]) + (2*F+23)'(p_q[2]) + (2*F+23)'(p_q[3]);
		unique case (sh_q)
			2'd0: rnd = acc;
			2'd1: rnd = (acc + ((2*F+23)'(1) <<< (F-1))) >>> F;
			2'd2: rnd = (acc + ((2*F+23)'(1) <<< F)) >>> (F+1);
			default: rnd = (acc + ((2*F+23)'(1) <<< (2*F-1))) >>> (2*F);
		endcase
	end

	assign q_take = (state_q == S_IDLE) && q_valid && !out_valid;

	logic st_we;
	assign st_we = q_take && q_item.cmd == ghi_pkg::CMD_STORE && st_idx < 19'(MAX_POINTS);

	always_ff @(posedge clk) begin
		if (st_we)
			hmem[st_idx[AW-1:0]] <= q_item.probed_height;
		rdata_s1 <= hmem[raddr[AW-1:0]];
	end

	// mark memory: one write port shared by store and wipe, registered read
	always_ff @(posedge clk) begin
		if (state_q == S_WIPE)
			emem[wipe_q] <= '0;
		else if (st_we)
			emem[st_idx[AW-1:0]] <= epoch_q;
		mark_s1 <= emem[raddr[AW-1:0]];
	end

	logic xe_n, ye_n;
	logic [9:0] cxn, cyn;
	always_comb begin
		cxn = clampc(px_q, nc, xe_n);
		cyn = clampc(py_q, nr, ye_n);
	end

	logic         bil_q, pass2_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_MAP: begin
				px_q <= dx * $signed({1'b0, inverse_spacing});
				py_q <= dy * $signed({1'b0, inverse_spacing});
			end
			S_CLAMP: begin
				xe_q <= xe_n;
				ye_q <= ye_n;
				fx_q <= px_q[31:32-F];
				fy_q <= py_q[31:32-F];
				base_q <= 20'(cyn * nc) + 20'(cxn);
			end
			default: ;
		endcase
		if (state_q == S_IDLE) it_q <= q_item;
		// corners that are not valid read as zero
		if (rvalid_s1) h_q[ridx_s1] <= rhit_s1 ? rdata_s1 : 16'sd0;
		if (state_q == S_MUL)
			for (int i = 0; i < 4; i++)
				p_q[i] <= (2*F+21)'($signed({1'b0, w_q[i]}) * h_q[i]);
	end

	// weights and shift selection
	always_ff @(posedge clk) begin
		if (state_q == S_WGT) begin
			for (int i = 0; i < 4; i++) w_q[i] <= '0;
			sh_q <= 2'd0;
			bil_q <= 1'b0;
			if (xe_q && ye_q) begin
				if (v_q[0]) w_q[0] <= (F+2)'(1);
			end else if (xe_q || ye_q) begin
				logic [F+1:0] f;
				logic hi;
				f  = xe_q ? fye : fxe;
				hi = xe_q ? v_q[2] : v_q[1];
				if (v_q[0] && hi) begin
					w_q[0] <= ONE - f;
					if (xe_q) w_q[2] <= f; else w_q[1] <= f;
					sh_q <= 2'd1;
				end else if (v_q[0]) w_q[0] <= (F+2)'(1);
				else if (hi) begin
					if (xe_q) w_q[2] <= (F+2)'(1); else w_q[1] <= (F+2)'(1);
				end
			end else begin
				unique case (v_q)
					4'd1: w_q[0] <= (F+2)'(1);
					4'd2: w_q[1] <= (F+2)'(1);
					4'd3: begin w_q[0] <= gxe; w_q[1] <= fxe; sh_q <= 2'd1; end
					4'd4: w_q[2] <= (F+2)'(1);
					4'd5: begin w_q[0] <= gye; w_q[2] <= fye; sh_q <= 2'd1; end
					4'd6: begin
						w_q[1] <= fxe + ONE - fye; w_q[2] <= fye + ONE - fxe; sh_q <= 2'd2;
					end
					4'd7: begin
						w_q[1] <= fxe; w_q[2] <= fye; w_q[0] <= TWO - fxe - fye; sh_q <= 2'd2;
					end
					4'd8: w_q[3] <= (F+2)'(1);
					4'd9: begin
						w_q[3] <= fxe + fye; w_q[0] <= TWO - fxe - fye; sh_q <= 2'd2;
					end
					4'd10: begin w_q[1] <= gye; w_q[3] <= fye; sh_q <= 2'd1; end
					4'd11: begin
						w_q[0] <= gxe; w_q[3] <= fye; w_q[1] <= TWO - gxe - fye; sh_q <= 2'd2;
					end
					4'd12: begin w_q[2] <= gxe; w_q[3] <= fxe; sh_q <= 2'd1; end
					4'd13: begin
						w_q[3] <= fxe; w_q[0] <= gye; w_q[2] <= TWO - fxe - gye; sh_q <= 2'd2;
					end
					4'd14: begin
						w_q[2] <= gxe; w_q[1] <= gye; w_q[3] <= TWO - gxe - gye; sh_q <= 2'd2;
					end
					4'd15: begin
						// exact bilinear: product of the two axis weights, 2F fraction
						bil_q <= 1'b1;
						sh_q  <= 2'd3;
					end
					default: ;
				endcase
			end
		end
	end

	// bilinear: p_i = (wx_i*wy_i) * h_i needs two multiplies; do wx*h in S_MUL,
	// then times wy in S_SUM pass
	logic [F+1:0] wyv [4];
	assign wyv[0] = gye;
	assign wyv[1] = gye;
	assign wyv[2] = fye;
	assign wyv[3] = fye;
	logic [F+1:0] wxv [4];
	assign wxv[0] = gxe;
	assign wxv[1] = fxe;
	assign wxv[2] = gxe;
	assign wxv[3] = fxe;
	logic signed [F+18:0] bx_q [4];
	logic signed [2*F+20:0] bp_q [4];

	always_ff @(posedge clk) begin
		if (state_q == S_MUL)
			for (int i = 0; i < 4; i++)
				bx_q[i] <= (F+19)'($signed({1'b0, wxv[i]}) * h_q[i]);
		if (pass2_q)
			for (int i = 0; i < 4; i++)
				bp_q[i] <= (2*F+21)'(bx_q[i] * $signed({1'b0, wyv[i]}));
	end

	logic signed [2*F+22:0] bacc, brnd;
	always_comb begin
		bacc = (2*F+23)'(bp_q[0]) + (2*F+23)'(bp_q[1]) + (2*F+23)'(bp_q[2])
			+ (2*F+23)'(bp_q[3]);
		brnd = (bacc + ((2*F+23)'(1) <<< (2*F-1))) >>> (2*F);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_WIPE;
			wipe_q    <= '0;
			epoch_q   <= EW'(1);
			out_valid <= 1'b0;
			rd_cnt_q  <= '0;
			rvalid_s1 <= 1'b0;
			vok_s1    <= 1'b0;
			ridx_s1   <= '0;
			v_q       <= '0;
			pass2_q   <= 1'b0;
			height_error <= '0;
			found     <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (rvalid_s1) v_q[ridx_s1] <= rhit_s1;
			rvalid_s1 <= 1'b0;
			pass2_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_take) begin
					unique case (q_item.cmd)
						ghi_pkg::CMD_STORE: begin
							found <= st_idx < 19'(MAX_POINTS);
							height_error <= '0;
							out_valid <= 1'b1;
						end
						ghi_pkg::CMD_CLEAR: begin
							// new epoch drops every mark; on wrap the marks are wiped
							if (epoch_q == '1) begin
								state_q <= S_WIPE;
								wipe_q  <= '0;
								epoch_q <= EW'(1);
							end else epoch_q <= epoch_q + EW'(1);
							found <= 1'b0;
							height_error <= '0;
							out_valid <= 1'b1;
						end
						ghi_pkg::CMD_QUERY: begin
							if (map_enable) state_q <= S_MAP;
							else begin
								found <= 1'b0; height_error <= '0; out_valid <= 1'b1;
							end
						end
						default: begin
							found <= 1'b0; height_error <= '0; out_valid <= 1'b1;
						end
					endcase
				end
				S_WIPE: begin
					wipe_q <= wipe_q + AW'(1);
					if (wipe_q == AW'(MAX_POINTS - 1)) state_q <= S_IDLE;
				end
				S_MAP: state_q <= S_CLAMP;
				S_CLAMP: begin
					state_q <= S_RD;
					rd_cnt_q <= '0;
					v_q <= '0;
				end
				S_RD: begin
					// issue reads for corners 0..3, then wait in this state for the last data
					if (!rd_cnt_q[2]) begin
						rvalid_s1 <= 1'b1;
						ridx_s1 <= ridx;
						vok_s1 <= cin[ridx] && raddr < 20'(MAX_POINTS);
						rd_cnt_q <= rd_cnt_q + 4'd1;
					end else state_q <= S_WGT;
				end
				S_WGT: state_q <= S_MUL;
				S_MUL: begin
					state_q <= S_SUM;
					pass2_q <= 1'b1;
				end
				S_SUM: state_q <= S_OUT;
				S_OUT: if (!out_valid) begin
					found <= v_q[0] || (v_q[1] && !xe_q) || (v_q[2] && !ye_q)
						|| (v_q[3] && !xe_q && !ye_q);
					height_error <= bil_q ? brnd[15:0] : rnd[15:0];
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/grid_height_interpolator_core.sv -----
// grid_height_interpolator_core: top level, register file, front queue and back sequencer
// depends on ghi_pkg, ghi_front, ghi_back
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   cmd col_index row_index probed_height pos_x pos_y
// out       output     out_valid/out_stall height_error found
// cfg       input      cfg_we              cfg_index cfg_data
//
// store, clear and unused commands: the back end registers the result as it takes the item
// from the queue; a query runs through map multiply, clamp, four corner reads from the single
// read port of the height memory, weights, two multiply steps and rounding, and the back end
// takes no other item until its result is registered
// reset clears registers and control, then a wipe over all MAX_POINTS marks clears them;
// every fifteenth clear runs the same wipe, items wait in the queue meanwhile
// the back end takes no item while a result waits; the two-entry front queue keeps
// taking items until it is full
module grid_height_interpolator_core #(
	parameter int MAX_POINTS = ghi_pkg::MaxPointsDef,
	parameter int FRAC_BITS  = ghi_pkg::FracBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [8:0]         col_index,
	input  logic [8:0]         row_index,
	input  logic signed [15:0] probed_height,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] height_error,
	output logic               found,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	// configuration registers
	logic               map_enable_q;
	logic signed [23:0] origin_x_q, origin_y_q;
	logic [31:0]        inv_spc_q;
	logic [9:0]         columns_q, rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_enable_q <= 1'b0;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			inv_spc_q    <= ghi_pkg::INV_SPC_RESET;
			columns_q    <= 10'd1;
			rows_q       <= 10'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ghi_pkg::REG_ENABLE:   map_enable_q <= cfg_data[0];
				ghi_pkg::REG_ORIGIN_X: origin_x_q   <= cfg_data[23:0];
				ghi_pkg::REG_ORIGIN_Y: origin_y_q   <= cfg_data[23:0];
				ghi_pkg::REG_INV_SPC:  inv_spc_q    <= cfg_data;
				ghi_pkg::REG_COLUMNS:  columns_q    <= cfg_data[9:0];
				ghi_pkg::REG_ROWS:     rows_q       <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	ghi_pkg::item_t in_item, q_item;
	logic q_valid, q_take;
	assign in_item = '{cmd: cmd, col_index: col_index, row_index: row_index,
		probed_height: probed_height, pos_x: pos_x, pos_y: pos_y};

	// front: item queue
	ghi_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item)
	);

	// back: store, clear and interpolation sequencer
	ghi_back #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item),
		.map_enable(map_enable_q), .origin_x(origin_x_q), .origin_y(origin_y_q),
		.inverse_spacing(inv_spc_q), .columns(columns_q), .rows(rows_q),
		.out_valid(out_valid), .out_stall(out_stall),
		.height_error(height_error), .found(found)
	);
endmodule

// ----- rtl/ghi_checker.sv -----
// ghi_checker: port-level assertions for the grid height interpolator, bound to the top
// depends on grid_height_interpolator_core
`timescale 1ns / 1ps
module ghi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] height_error,
	input logic        found
);
	// a result held under stall keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(height_error) && $stable(found))
		else $error("result changed under stall");
	// no result straight after reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result after reset");
	// a result that was not found carries zero height
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> height_error == 16'd0)
		else $error("height without a found corner");
	// the input side only fills up after taking an item
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && !in_stall) |=> !$rose(in_stall))
		else $error("input stalled without a new item");
endmodule

bind grid_height_interpolator_core ghi_checker u_ghi_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .height_error(height_error),
	.found(found)
);

// ----- test/grid_height_checker.sv -----
// grid_height_checker: watches the item, result and register channels of the interpolator core
// predicts every result from its own copy of the grid and registers; depends on ghi_pkg
`timescale 1ns / 1ps
module grid_height_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [8:0]         col_index,
	input  logic [8:0]         row_index,
	input  logic signed [15:0] probed_height,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] height_error,
	input  logic               found,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 errors,
	output int                 pending,
	output int                 checked
);
	localparam int NPts = 512;
	localparam int FBits = 16;
	localparam longint One = longint'(1) << FBits;
	localparam longint Two = One * 2;

	typedef struct packed {
		logic signed [15:0] height;
		logic               hit;
	} height_result_t;

	logic signed [15:0] heights [NPts];
	logic [NPts-1:0]    marks;
	logic               en;
	longint             org_x, org_y;
	logic [31:0]        inv_spc;
	logic [9:0]         ncols, nrows;
	height_result_t     expected_heights [$];

	function automatic longint rshift_round(input longint num, input int sh);
		longint base;
		base = 1;
		return (num + (base << (sh - 1))) >>> sh;
	endfunction

	function automatic void map_axis(input logic signed [23:0] pos, input longint org,
			output longint cidx, output longint frac);
		longint d, p;
		logic [63:0] q;
		d = longint'(pos) - org;
		p = d * longint'({32'd0, inv_spc});
		q = p + 64'h0100_0000_0000_0000;
		cidx = longint'(q >> 32) - (longint'(1) << 24);
		frac = longint'(q[31:32-FBits]);
	endfunction

	function automatic longint clamp_cell(input longint cidx, input int count,
			output bit at_edge);
		at_edge = 1'b1;
		if (cidx < 0)
			return 0;
		if (cidx >= count - 1)
			return count - 1;
		at_edge = 1'b0;
		return cidx;
	endfunction

	function automatic bit fetch(input longint c, input longint r, input int stride,
			output longint h);
		longint idx;
		idx = r * stride + c;
		h = 0;
		if (idx >= NPts || !marks[idx])
			return 1'b0;
		h = heights[idx];
		return 1'b1;
	endfunction

	function automatic longint lerp(input longint h1, input longint h2, input longint f);
		return rshift_round((One - f) * h1 + f * h2, FBits);
	endfunction

	function automatic longint tri_mix(input longint hc, input longint ha, input longint hb,
			input longint a, input longint b);
		return rshift_round(a * ha + b * hb + (Two - a - b) * hc, FBits + 1);
	endfunction

	function automatic height_result_t predict_height(input logic signed [23:0] px,
			input logic signed [23:0] py);
		height_result_t res;
		int nc, nr;
		longint xi, yi, fx, fy, cx, cy, h00, h10, h01, h11, h;
		bit xe, ye, v00, v10, v01, v11;
		logic [3:0] mask;
		nc = (ncols == 0) ? 1 : int'(ncols);
		nr = (nrows == 0) ? 1 : int'(nrows);
		map_axis(px, org_x, xi, fx);
		map_axis(py, org_y, yi, fy);
		cx = clamp_cell(xi, nc, xe);
		cy = clamp_cell(yi, nr, ye);
		h10 = 0; h01 = 0; h11 = 0;
		v10 = 0; v01 = 0; v11 = 0;
		v00 = fetch(cx, cy, nc, h00);
		if (!xe)
			v10 = fetch(cx + 1, cy, nc, h10);
		if (!ye)
			v01 = fetch(cx, cy + 1, nc, h01);
		if (!xe && !ye)
			v11 = fetch(cx + 1, cy + 1, nc, h11);
		res.hit = v00 | v10 | v01 | v11;
		mask = {v11, v01, v10, v00};
		if (xe && ye) begin
			h = v00 ? h00 : 0;
		end else if (xe) begin
			h = (v00 && v01) ? lerp(h00, h01, fy) : (v00 ? h00 : (v01 ? h01 : 0));
		end else if (ye) begin
			h = (v00 && v10) ? lerp(h00, h10, fx) : (v00 ? h00 : (v10 ? h10 : 0));
		end else begin
			case (mask)
				4'd1: h = h00;
				4'd2: h = h10;
				4'd3: h = lerp(h00, h10, fx);
				4'd4: h = h01;
				4'd5: h = lerp(h00, h01, fy);
				4'd6: h = rshift_round((fx + One - fy) * h10 + (fy + One - fx) * h01, FBits + 1);
				4'd7: h = tri_mix(h00, h10, h01, fx, fy);
				4'd8: h = h11;
				4'd9: h = rshift_round((fx + fy) * h11 + (Two - fx - fy) * h00, FBits + 1);
				4'd10: h = lerp(h10, h11, fy);
				4'd11: h = tri_mix(h10, h00, h11, One - fx, fy);
				4'd12: h = lerp(h01, h11, fx);
				4'd13: h = tri_mix(h01, h11, h00, fx, One - fy);
				4'd14: h = tri_mix(h11, h01, h10, One - fx, One - fy);
				4'd15: h = rshift_round(((One - fx) * h00 + fx * h10) * (One - fy)
					+ ((One - fx) * h01 + fx * h11) * fy, 2 * FBits);
				default: h = 0;
			endcase
		end
		if (h > 32767)
			h = 32767;
		if (h < -32768)
			h = -32768;
		res.height = h[15:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		height_result_t exp_r;
		int idx, nc;
		if (!arst_n) begin
			marks = '0;
			en = 1'b0;
			org_x = 0;
			org_y = 0;
			inv_spc = ghi_pkg::INV_SPC_RESET;
			ncols = 10'd1;
			nrows = 10'd1;
			errors = 0;
			checked = 0;
			pending = 0;
			expected_heights.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ghi_pkg::REG_ENABLE:   en = cfg_data[0];
					ghi_pkg::REG_ORIGIN_X: org_x = longint'($signed(cfg_data[23:0]));
					ghi_pkg::REG_ORIGIN_Y: org_y = longint'($signed(cfg_data[23:0]));
					ghi_pkg::REG_INV_SPC:  inv_spc = cfg_data;
					ghi_pkg::REG_COLUMNS:  ncols = cfg_data[9:0];
					ghi_pkg::REG_ROWS:     nrows = cfg_data[9:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				exp_r = '0;
				if (cmd == ghi_pkg::CMD_STORE) begin
					nc = (ncols == 0) ? 1 : int'(ncols);
					idx = int'(row_index) * nc + int'(col_index);
					if (idx < NPts) begin
						heights[idx] = probed_height;
						marks[idx] = 1'b1;
						exp_r.hit = 1'b1;
					end
				end else if (cmd == ghi_pkg::CMD_CLEAR) begin
					marks = '0;
				end else if (cmd == ghi_pkg::CMD_QUERY && en) begin
					exp_r = predict_height(pos_x, pos_y);
				end
				expected_heights.push_back(exp_r);
			end
			if (out_valid && !out_stall) begin
				if (expected_heights.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none actual height_error %0d found %0b",
						$time, height_error, found);
				end else begin
					exp_r = expected_heights.pop_front();
					checked++;
					if (height_error !== exp_r.height) begin
						errors++;
						$display("%0t height_error mismatch: expected %0d actual %0d",
							$time, exp_r.height, height_error);
					end
					if (found !== exp_r.hit) begin
						errors++;
						$display("%0t found mismatch: expected %0b actual %0b",
							$time, exp_r.hit, found);
					end
				end
			end
			pending = expected_heights.size();
		end
	end
endmodule

// ----- test/grid_height_interpolator_core_test.sv -----
// grid_height_interpolator_core_test: stimulus and verdict for the interpolator core
// depends on ghi_pkg, grid_height_interpolator_core and grid_height_checker
`timescale 1ns / 1ps
module grid_height_interpolator_core_test;
	// the one command code the package leaves unnamed
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         cmd;
	logic [8:0]         col_index;
	logic [8:0]         row_index;
	logic signed [15:0] probed_height;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] height_error;
	logic               found;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	int errors, pending, checked;
	int idle_pct, stall_pct;
	int items_sent, settings_used;

	// mirror of the grid geometry, used only to aim stimulus at the grid
	int          g_cols, g_rows;
	longint      g_ox, g_oy;
	logic [31:0] g_inv;

	grid_height_interpolator_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .col_index(col_index), .row_index(row_index),
		.probed_height(probed_height), .pos_x(pos_x), .pos_y(pos_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.height_error(height_error), .found(found),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	grid_height_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .col_index(col_index), .row_index(row_index),
		.probed_height(probed_height), .pos_x(pos_x), .pos_y(pos_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.height_error(height_error), .found(found),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .checked(checked)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// receiver side: stall decided afresh every falling edge
	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// one item; returns just after the rising edge that took it
	task automatic send(input logic [1:0] c, input int col, input int row,
			input int h, input longint x, input longint y);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		cmd = c;
		col_index = col[8:0];
		row_index = row[8:0];
		probed_height = h[15:0];
		pos_x = x[23:0];
		pos_y = y[23:0];
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		items_sent++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
	endtask

	// let the core drain before touching the registers
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_grid(input bit en, input longint ox, input longint oy,
			input logic [31:0] inv, input int cols, input int rows);
		drain();
		write_reg(ghi_pkg::REG_ENABLE, {31'd0, en});
		write_reg(ghi_pkg::REG_ORIGIN_X, {8'd0, ox[23:0]});
		write_reg(ghi_pkg::REG_ORIGIN_Y, {8'd0, oy[23:0]});
		write_reg(ghi_pkg::REG_INV_SPC, inv);
		write_reg(ghi_pkg::REG_COLUMNS, cols);
		write_reg(ghi_pkg::REG_ROWS, rows);
		@(negedge clk);
		cfg_we = 1'b0;
		g_ox = ox; g_oy = oy; g_inv = inv; g_cols = cols; g_rows = rows;
		settings_used++;
	endtask

	function automatic longint clip24(input longint v);
		if (v > 8388607)
			return 8388607;
		if (v < -8388608)
			return -8388608;
		return v;
	endfunction

	// position near the grid along one axis, a cell beyond each edge included
	function automatic longint aim(input longint org, input int count);
		longint spc, span;
		if (g_inv == 0)
			return longint'($signed(24'($urandom)));
		spc = (longint'(1) << 32) / longint'({32'd0, g_inv});
		if (spc == 0)
			spc = 1;
		span = spc * (count + 1);
		if (span > 16777215)
			span = 16777215;
		return clip24(org - spc + longint'($urandom_range(int'(span))));
	endfunction

	task automatic random_phase(input int n);
		int pts, density, k, idx;
		pts = g_cols * g_rows;
		if (pts > 512)
			pts = 512;
		density = $urandom_range(100, 30);
		send(ghi_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
		// seed the grid with a random share of its points
		for (k = 0; k < pts * density / 100 && k < 40; k++) begin
			idx = $urandom_range(pts - 1);
			send(ghi_pkg::CMD_STORE, idx % g_cols, idx / g_cols, $urandom, 0, 0);
		end
		for (k = 0; k < n; k++) begin
			case ($urandom_range(99)) inside
				[0:29]: begin
					idx = $urandom_range(pts - 1);
					send(ghi_pkg::CMD_STORE, idx % g_cols, idx / g_cols, $urandom, 0, 0);
				end
				[30:84]:
					send(ghi_pkg::CMD_QUERY, $urandom, $urandom, $urandom,
						aim(g_ox, g_cols), aim(g_oy, g_rows));
				[85:87]:
					send(ghi_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom,
						$urandom);
				[88:92]:
					send(ghi_pkg::CMD_STORE, $urandom, $urandom, $urandom, $urandom,
						$urandom);
				[93:97]:
					send(ghi_pkg::CMD_QUERY, $urandom, $urandom, $urandom,
						longint'($signed(24'($urandom))), longint'($signed(24'($urandom))));
				default:
					send(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
			endcase
		end
	endtask

	initial begin
		int p, mode;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = ghi_pkg::CMD_STORE;
		col_index = '0;
		row_index = '0;
		probed_height = '0;
		pos_x = '0;
		pos_y = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ghi_pkg::REG_ENABLE;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		settings_used = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// straight after reset the map is disabled: query gives zero
		g_cols = 1; g_rows = 1;
		send(ghi_pkg::CMD_STORE, 0, 0, 77, 0, 0);
		send(ghi_pkg::CMD_QUERY, 0, 0, 0, 0, 0);

		// directed checks on a 4 by 3 grid with a spacing of 2560 position units
		set_grid(1'b1, 0, 0, 32'd1677722, 4, 3);
		send(ghi_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
		send(ghi_pkg::CMD_STORE, 0, 0, 32767, 0, 0);
		send(ghi_pkg::CMD_STORE, 1, 0, -32768, 0, 0);
		send(ghi_pkg::CMD_STORE, 0, 1, 0, 0, 0);
		send(ghi_pkg::CMD_STORE, 1, 1, 1234, 0, 0);
		send(ghi_pkg::CMD_QUERY, 0, 0, 0, 1280, 1280);           // bilinear, middle of cell
		send(ghi_pkg::CMD_QUERY, 0, 0, 0, 0, 0);                 // exactly on a grid point
		send(ghi_pkg::CMD_QUERY, 0, 0, 0, -8388608, -8388608);   // below the grid on both axes
		send(ghi_pkg::CMD_QUERY, 0, 0, 0, 8388607, 8388607);     // past the far corner
		send(ghi_pkg::CMD_QUERY, 0, 0, 0, 8388607, 1000);        // clamped column, linear in Y
		send(ghi_pkg::CMD_QUERY, 0, 0, 0, 700, -8388608);        // clamped row, linear in X
		send(ghi_pkg::CMD_STORE, 511, 511, 5, 0, 0);             // off the store, ignored
		send(ghi_pkg::CMD_STORE, 5, 0, -100, 0, 0);              // wraps into the next row
		send(CMD_UNUSED, 511, 511, -1, -1, -1);
		send(ghi_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
		send(ghi_pkg::CMD_QUERY, 0, 0, 0, 1280, 1280);           // nothing valid
		send(ghi_pkg::CMD_STORE, 1, 0, 3000, 0, 0);
		send(ghi_pkg::CMD_STORE, 0, 1, -3000, 0, 0);
		send(ghi_pkg::CMD_QUERY, 0, 0, 0, 900, 300);             // anti-diagonal pair
		send(ghi_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
		send(ghi_pkg::CMD_STORE, 0, 0, 2000, 0, 0);
		send(ghi_pkg::CMD_STORE, 1, 1, -500, 0, 0);
		send(ghi_pkg::CMD_QUERY, 0, 0, 0, 1900, 600);            // main diagonal pair
		send(ghi_pkg::CMD_STORE, 1, 0, 800, 0, 0);
		send(ghi_pkg::CMD_QUERY, 0, 0, 0, 400, 2300);            // three corners

		// random phases over several geometries; idling mode rotates
		for (p = 0; p < 12; p++) begin
			case (p)
				0: set_grid(1'b1, -1000, 2000, 32'd1677722, 8, 6);
				1: set_grid(1'b0, -1000, 2000, 32'd1677722, 8, 6);
				2: set_grid(1'b1, -8388608, -8388608, 32'hFFFF_FFFF, 3, 2);
				3: set_grid(1'b1, 8388607, 8388607, 32'd0, 512, 1);
				4: set_grid(1'b1, 0, 0, 32'd838861, 1, 512);
				5: set_grid(1'b1, 12345, -777, 32'd3355443, 22, 23);
				6: set_grid(1'b1, 0, 0, 32'd16777216, 512, 512);
				7: set_grid(1'b1, 300, -300, 32'd65536 << $urandom_range(10), 2, 2);
				default: set_grid(1'b1, $signed(16'($urandom)), $signed(16'($urandom)),
					$urandom_range(8000000, 300000), $urandom_range(32, 1),
					$urandom_range(16, 1));
			endcase
			mode = p % 4;
			idle_pct = (mode == 1) ? 72 : ((mode == 3) ? 20 : 0);
			stall_pct = (mode == 2) ? 72 : ((mode == 3) ? 20 : 0);
			random_phase(28);
		end

		idle_pct = 0;
		stall_pct = 0;
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d items under %0d register settings, %0d results compared",
			items_sent, settings_used, checked);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/ghi_pkg.sv
rtl/ghi_front.sv
rtl/ghi_back.sv
rtl/grid_height_interpolator_core.sv
rtl/ghi_checker.sv
test/grid_height_checker.sv
test/grid_height_interpolator_core_test.sv
